### hdl/lattice_particle_occupancy_table_macros.svh
// Assertion macros shared by the checker of the particle occupancy table.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef LATTICE_PARTICLE_OCCUPANCY_TABLE_MACROS_SVH
`define LATTICE_PARTICLE_OCCUPANCY_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPOT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpot assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPOT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpot assertion failed");

`endif

### hdl/lpot_pkg.sv
// Shared types and constants of the lattice particle occupancy table.
// No dependencies; used by the top level, the RAM users and the checker.
`default_nettype none

package lpot_pkg;

   localparam int MAX_SITES     = 256;
   localparam int MAX_PARTICLES = 256;

   localparam int SITE_W  = $clog2(MAX_SITES);
   localparam int PART_W  = $clog2(MAX_PARTICLES);
   localparam int COUNT_W = 9;
   localparam int CFG_W   = 9;

   localparam logic [2:0] OP_ADD       = 3'd0;
   localparam logic [2:0] OP_CHECK     = 3'd1;
   localparam logic [2:0] OP_MOVE      = 3'd2;
   localparam logic [2:0] OP_READ_SITE = 3'd3;
   localparam logic [2:0] OP_READ_PART = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SITE_RANGE = 3'd1;
   localparam logic [2:0] ST_PART_RANGE = 3'd2;
   localparam logic [2:0] ST_SAME_SITE  = 3'd3;
   localparam logic [2:0] ST_OCCUPIED   = 3'd4;
   localparam logic [2:0] ST_FULL       = 3'd5;

   localparam logic REG_SITES_IN_USE = 1'b0;
   localparam logic REG_HARD_CORE    = 1'b1;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] site;
      logic [7:0] particle;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [COUNT_W-1:0] value;
      logic [COUNT_W-1:0] particle_count;
   } rsp_word_type;

endpackage

`default_nettype wire

### hdl/lattice_particle_occupancy_table.sv
// Lattice particle occupancy table: per-site occupation counts and the site
// of every numbered particle, kept in two RAMs with registered reads.
// Depends on lpot_pkg and lpot_ram.
//
// Use: one operation word enters on req_ (valid/stall); exactly one result
// word leaves on rsp_ (valid/stall). Registers are written on csr_
// (valid/ready, always ready) and should only change while the block is idle.
// One operation at a time: req_stall is high from the cycle after acceptance
// until the result has been placed in the output register. The result is
// loaded in state S_LOOK (add, check, reads, refused move) or, for an
// accepted move, in S_FIX, since its source site count is read from the
// occupation RAM only after the particle's site has come out of the other
// RAM; while the output register is held, the result waits in S_DONE. A new
// word can be accepted only once the result has been loaded.
// A result held by rsp_stall stays in the output register; the next word is
// still taken and worked on, and waits for the register only at its end.
// Reset (synchronous) empties the tables at once: occupation entries carry
// valid bits that reset clears, so no clearing pass is needed.
`default_nettype none

module lattice_particle_occupancy_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lpot_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lpot_pkg::rsp_word_type     rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [8:0]            csr_data
);

   import lpot_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_FIX  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   req_word_type       op_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CFG_W-1:0]   sites_ff;
   logic               hard_ff;
   logic [MAX_SITES-1:0] occ_valid_ff;
   logic [SITE_W-1:0]  src_ff;
   rsp_word_type       res_ff, res_in;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;

   // Occupation RAM ports
   logic               occ_wr_en;
   logic [SITE_W-1:0]  occ_wr_addr;
   logic [COUNT_W-1:0] occ_wr_data;
   logic [SITE_W-1:0]  occ_rd_addr;
   logic [COUNT_W-1:0] occ_rd_data;
   // Particle site RAM ports
   logic               ps_wr_en;
   logic [PART_W-1:0]  ps_wr_addr;
   logic [SITE_W-1:0]  ps_wr_data;
   logic [PART_W-1:0]  ps_rd_addr;
   logic [SITE_W-1:0]  ps_rd_data;

   logic               accept;
   logic               out_free;
   logic               load_rsp;
   logic [CFG_W-1:0]   site_limit;
   logic [COUNT_W-1:0] occ_dest;
   logic [COUNT_W-1:0] occ_src;
   logic [2:0]         move_status;

   lpot_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_SITES)) u_occ_ram (
      .clock   (clock),
      .wr_en   (occ_wr_en),
      .wr_addr (occ_wr_addr),
      .wr_data (occ_wr_data),
      .rd_addr (occ_rd_addr),
      .rd_data (occ_rd_data)
   );

   lpot_ram #(.WIDTH(SITE_W), .DEPTH(MAX_PARTICLES)) u_psite_ram (
      .clock   (clock),
      .wr_en   (ps_wr_en),
      .wr_addr (ps_wr_addr),
      .wr_data (ps_wr_data),
      .rd_addr (ps_rd_addr),
      .rd_data (ps_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign site_limit = (sites_ff > CFG_W'(MAX_SITES)) ? CFG_W'(MAX_SITES) : sites_ff;

   // A site never written since reset reads as empty.
   assign occ_dest = occ_valid_ff[op_ff.site] ? occ_rd_data : '0;
   assign occ_src  = occ_valid_ff[src_ff] ? occ_rd_data : '0;

   always_comb begin
      if (COUNT_W'(op_ff.particle) >= count_ff) begin
         move_status = ST_PART_RANGE;
      end else if (CFG_W'(op_ff.site) >= site_limit) begin
         move_status = ST_SITE_RANGE;
      end else if (ps_rd_data == op_ff.site) begin
         move_status = ST_SAME_SITE;
      end else if (hard_ff && (occ_dest != '0)) begin
         move_status = ST_OCCUPIED;
      end else begin
         move_status = ST_OK;
      end
   end

   // Read addresses: the word's own site and particle at acceptance, then the
   // moving particle's old site once it is known.
   assign occ_rd_addr = (state_ff == S_LOOK) ? ps_rd_data : req_data.site;
   assign ps_rd_addr  = req_data.particle;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      res_in      = res_ff;
      occ_wr_en   = 1'b0;
      occ_wr_addr = op_ff.site;
      occ_wr_data = occ_dest + COUNT_W'(1);
      ps_wr_en    = 1'b0;
      ps_wr_addr  = count_ff[PART_W-1:0];
      ps_wr_data  = op_ff.site;
      load_rsp    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            res_in.status = ST_OK;
            res_in.value  = '0;
            unique case (op_ff.opcode)
               OP_ADD: begin
                  if (CFG_W'(op_ff.site) >= site_limit) begin
                     res_in.status = ST_SITE_RANGE;
                  end else if (count_ff >= COUNT_W'(MAX_PARTICLES)) begin
                     res_in.status = ST_FULL;
                  end else if (hard_ff && (occ_dest != '0)) begin
                     res_in.status = ST_OCCUPIED;
                  end else begin
                     occ_wr_en = 1'b1;
                     ps_wr_en  = 1'b1;
                     count_in  = count_ff + COUNT_W'(1);
                  end
               end
               OP_CHECK: begin
                  res_in.status = move_status;
                  res_in.value  = COUNT_W'(move_status == ST_OK);
               end
               OP_MOVE: begin
                  res_in.status = move_status;
                  if (move_status == ST_OK) begin
                     occ_wr_en  = 1'b1;
                     ps_wr_en   = 1'b1;
                     ps_wr_addr = op_ff.particle[PART_W-1:0];
                  end
               end
               OP_READ_SITE: begin
                  if (CFG_W'(op_ff.site) >= site_limit) begin
                     res_in.status = ST_SITE_RANGE;
                  end else begin
                     res_in.value = occ_dest;
                  end
               end
               OP_READ_PART: begin
                  if (COUNT_W'(op_ff.particle) >= count_ff) begin
                     res_in.status = ST_PART_RANGE;
                  end else begin
                     res_in.value = COUNT_W'(ps_rd_data);
                  end
               end
               default: begin
               end
            endcase
            res_in.particle_count = count_in;

            if ((op_ff.opcode == OP_MOVE) && (move_status == ST_OK)) begin
               state_in = S_FIX;
            end else if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIX: begin
            // The source differs from the destination, so this write never
            // collides with the increment written in state S_LOOK.
            occ_wr_addr = src_ff;
            occ_wr_data = occ_src - COUNT_W'(1);
            occ_wr_en   = (occ_src != '0);
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sites_ff     <= CFG_W'(MAX_SITES);
         hard_ff      <= 1'b0;
         occ_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_SITES_IN_USE: sites_ff <= csr_data;
               REG_HARD_CORE:    hard_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (occ_wr_en) begin
            occ_valid_ff[occ_wr_addr] <= 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_data;
      end
      if (state_ff == S_LOOK) begin
         src_ff <= ps_rd_data;
      end
      res_ff <= res_in;
      if (load_rsp) begin
         rsp_data_ff <= (state_ff == S_LOOK) ? res_in : res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### hdl/lpot_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; width and depth come from the parameters.
`default_nettype none

module lpot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/lpot_checker.sv
// Port-level checker for the lattice particle occupancy table, bound to the top level.
// Depends on lpot_pkg and the assertion macro header.
`default_nettype none
`include "lattice_particle_occupancy_table_macros.svh"

module lpot_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire lpot_pkg::rsp_word_type rsp_data
);

   import lpot_pkg::*;

   // The block works on one word at a time, so it is busy right after accepting.
   `LPOT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A held result word stays put.
   `LPOT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Refused operations report no value.
   `LPOT_ASSERT_SAME(a_error_no_value, clock, reset, rsp_valid && (rsp_data.status != ST_OK), rsp_data.value == '0)

   // The particle table never holds more than its capacity.
   `LPOT_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid, rsp_data.particle_count <= COUNT_W'(MAX_PARTICLES))

endmodule

bind lattice_particle_occupancy_table lpot_checker u_lpot_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench of lattice_particle_occupancy_table: directed words, then
// random phases under several register settings, checked against a behavioral model.
// Depends on lpot_pkg and the block's RTL.
`default_nettype none

module testbench;
   import lpot_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      req_word_type w;
      logic         typed;
      rsp_word_type r;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [8:0]   csr_data;

   // Behavioral copy of the tables and registers.
   logic [8:0]   occ_model [MAX_SITES];
   logic [7:0]   where_is [MAX_PARTICLES];
   logic [8:0]   placed;
   logic [8:0]   cfg_sites;
   logic         cfg_hard_core;

   rsp_word_type awaited_results [$];
   stim_row_type directed_rows [23];
   int           error_count;
   int           sent_count;
   int           taken_count;
   int           cycle_count;
   bit           send_calm;
   bit           take_calm;

   lattice_particle_occupancy_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [2:0] move_verdict(input logic [7:0] p, input logic [7:0] d,
                                               input logic [8:0] lim);
      if ({1'b0, p} >= placed)
         return ST_PART_RANGE;
      if ({1'b0, d} >= lim)
         return ST_SITE_RANGE;
      if (where_is[p] == d)
         return ST_SAME_SITE;
      if (cfg_hard_core && occ_model[d] != 9'd0)
         return ST_OCCUPIED;
      return ST_OK;
   endfunction

   // Applies one operation to the model tables and returns the result word it gives.
   function automatic rsp_word_type apply_lattice_op(input req_word_type w);
      rsp_word_type r;
      logic [8:0]   lim;
      logic [7:0]   src;
      lim = (cfg_sites > 9'd256) ? 9'd256 : cfg_sites;
      r.status = ST_OK;
      r.value  = '0;
      case (w.opcode)
         OP_ADD: begin
            if ({1'b0, w.site} >= lim)
               r.status = ST_SITE_RANGE;
            else if (placed >= 9'(MAX_PARTICLES))
               r.status = ST_FULL;
            else if (cfg_hard_core && occ_model[w.site] != 9'd0)
               r.status = ST_OCCUPIED;
            else begin
               where_is[placed[7:0]] = w.site;
               occ_model[w.site] = occ_model[w.site] + 9'd1;
               placed = placed + 9'd1;
            end
         end
         OP_CHECK: begin
            r.status = move_verdict(w.particle, w.site, lim);
            r.value  = (r.status == ST_OK) ? 9'd1 : 9'd0;
         end
         OP_MOVE: begin
            r.status = move_verdict(w.particle, w.site, lim);
            if (r.status == ST_OK) begin
               src = where_is[w.particle];
               if (occ_model[src] != 9'd0)
                  occ_model[src] = occ_model[src] - 9'd1;
               occ_model[w.site] = occ_model[w.site] + 9'd1;
               where_is[w.particle] = w.site;
            end
         end
         OP_READ_SITE: begin
            if ({1'b0, w.site} >= lim)
               r.status = ST_SITE_RANGE;
            else
               r.value = occ_model[w.site];
         end
         OP_READ_PART: begin
            if ({1'b0, w.particle} >= placed)
               r.status = ST_PART_RANGE;
            else
               r.value = {1'b0, where_is[w.particle]};
         end
         default: begin
         end
      endcase
      r.particle_count = placed;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word was taken.
   task automatic offer_word(input req_word_type w, input logic typed,
                             input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type predicted;
      gap = send_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      predicted = apply_lattice_op(w);
      if (typed)
         predicted = typed_rsp;
      awaited_results.insert(awaited_results.size(), predicted);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      sent_count++;
      if (sent_count % 40 == 0)
         send_calm = ($urandom_range(0, 3) == 0);
   endtask

   // Leaves csr_valid high; the caller lowers it after its last write.
   task automatic write_csr(input logic idx, input logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      if (idx == REG_SITES_IN_USE)
         cfg_sites = val;
      else
         cfg_hard_core = val[0];
   endtask

   // Drains the block, sets both registers, then sends a weighted random mix.
   task automatic run_phase(input logic [8:0] sites, input logic hard_core, input int items,
                            input int add_w, input int move_w);
      req_word_type w;
      logic [8:0]   lim;
      int           pick;
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
      write_csr(REG_SITES_IN_USE, sites);
      write_csr(REG_HARD_CORE, {8'd0, hard_core});
      csr_valid <= 1'b0;
      for (int i = 0; i < items; i++) begin
         lim  = (cfg_sites > 9'd256) ? 9'd256 : cfg_sites;
         pick = $urandom_range(0, 99);
         if (pick < add_w)
            w.opcode = OP_ADD;
         else if (pick < add_w + move_w)
            w.opcode = ($urandom_range(0, 2) == 0) ? OP_CHECK : OP_MOVE;
         else if (pick < 95)
            w.opcode = ($urandom_range(0, 1) == 0) ? OP_READ_SITE : OP_READ_PART;
         else
            w.opcode = 3'($urandom_range(5, 7));
         if (lim != 9'd0 && $urandom_range(0, 7) != 0)
            w.site = 8'($urandom_range(0, lim - 1));
         else
            w.site = 8'($urandom_range(0, 255));
         if (placed != 9'd0 && $urandom_range(0, 7) != 0)
            w.particle = 8'($urandom_range(0, placed - 1));
         else
            w.particle = 8'($urandom_range(0, 255));
         offer_word(w, 1'b0, '0);
      end
   endtask

   // Result side: random stall before each word, and two long hold-offs.
   initial begin : result_sink
      int gap;
      rsp_word_type want;
      rsp_stall = 1'b1;
      take_calm = 1'b0;
      taken_count = 0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = take_calm ? 0 : $urandom_range(0, 11);
         if (taken_count == 100 || taken_count == 400)
            gap = 300;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (awaited_results.size() == 0) begin
            $error("result word with no expectation: status %0d value %0d count %0d",
                   rsp_data.status, rsp_data.value, rsp_data.particle_count);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, rsp_data.value);
               error_count++;
            end
            if (rsp_data.particle_count !== want.particle_count) begin
               $error("particle_count: expected %0d, got %0d",
                      want.particle_count, rsp_data.particle_count);
               error_count++;
            end
         end
         taken_count++;
         if (taken_count % 40 == 0)
            take_calm = ($urandom_range(0, 3) == 0);
         @(negedge clock);
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_index     = 1'b0;
      csr_data      = '0;
      cycle_count   = 0;
      error_count   = 0;
      sent_count    = 0;
      send_calm     = 1'b0;
      placed        = '0;
      cfg_sites     = 9'd256;
      cfg_hard_core = 1'b0;
      for (int i = 0; i < MAX_SITES; i++)
         occ_model[i] = '0;
      for (int i = 0; i < MAX_PARTICLES; i++)
         where_is[i] = '0;

      // Rows with the typed flag set carry their result; the rest use the model.
      directed_rows[0]  = {OP_READ_SITE, 8'd0,   8'd0,   1'b1, ST_OK,         9'd0,   9'd0};
      directed_rows[1]  = {OP_READ_PART, 8'd0,   8'd0,   1'b1, ST_PART_RANGE, 9'd0,   9'd0};
      directed_rows[2]  = {OP_CHECK,     8'd5,   8'd0,   1'b1, ST_PART_RANGE, 9'd0,   9'd0};
      directed_rows[3]  = {OP_MOVE,      8'd5,   8'd0,   1'b1, ST_PART_RANGE, 9'd0,   9'd0};
      directed_rows[4]  = {OP_ADD,       8'd255, 8'd0,   1'b1, ST_OK,         9'd0,   9'd1};
      directed_rows[5]  = {OP_ADD,       8'd0,   8'd255, 1'b1, ST_OK,         9'd0,   9'd2};
      directed_rows[6]  = {OP_ADD,       8'd0,   8'd0,   1'b1, ST_OK,         9'd0,   9'd3};
      directed_rows[7]  = {OP_READ_SITE, 8'd0,   8'd0,   1'b1, ST_OK,         9'd2,   9'd3};
      directed_rows[8]  = {OP_READ_PART, 8'd0,   8'd0,   1'b1, ST_OK,         9'd255, 9'd3};
      directed_rows[9]  = {OP_CHECK,     8'd255, 8'd0,   1'b1, ST_SAME_SITE,  9'd0,   9'd3};
      directed_rows[10] = {OP_MOVE,      8'd255, 8'd0,   1'b1, ST_SAME_SITE,  9'd0,   9'd3};
      directed_rows[11] = {OP_CHECK,     8'd7,   8'd1,   1'b1, ST_OK,         9'd1,   9'd3};
      directed_rows[12] = {OP_MOVE,      8'd7,   8'd1,   1'b1, ST_OK,         9'd0,   9'd3};
      directed_rows[13] = {OP_READ_SITE, 8'd0,   8'd0,   1'b1, ST_OK,         9'd1,   9'd3};
      directed_rows[14] = {OP_READ_PART, 8'd0,   8'd1,   1'b1, ST_OK,         9'd7,   9'd3};
      directed_rows[15] = {3'd5,         8'd255, 8'd255, 1'b1, ST_OK,         9'd0,   9'd3};
      directed_rows[16] = {3'd6,         8'd0,   8'd0,   1'b1, ST_OK,         9'd0,   9'd3};
      directed_rows[17] = {3'd7,         8'd170, 8'd85,  1'b1, ST_OK,         9'd0,   9'd3};
      directed_rows[18] = {OP_READ_PART, 8'd0,   8'd255, 1'b1, ST_PART_RANGE, 9'd0,   9'd3};
      directed_rows[19] = {OP_MOVE,      8'd0,   8'd3,   1'b1, ST_PART_RANGE, 9'd0,   9'd3};
      directed_rows[20] = {OP_ADD,       8'd170, 8'd85,  1'b0, 21'd0};
      directed_rows[21] = {OP_MOVE,      8'd255, 8'd3,   1'b0, 21'd0};
      directed_rows[22] = {OP_READ_SITE, 8'd255, 8'd0,   1'b0, 21'd0};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].r);

      // No site in range at all.
      run_phase(9'd0, 1'b0, 20, 30, 40);
      // Small lattice, particles pile up on shared sites.
      run_phase(9'd16, 1'b0, 120, 40, 35);
      // Hard core switched on over sites that already hold several particles.
      run_phase(9'd16, 1'b1, 60, 25, 45);
      // Shrunk lattice: particles beyond the limit can still be moved away and read.
      run_phase(9'd5, 1'b1, 50, 20, 50);
      // Full lattice, mostly adds, so the particle table fills up.
      run_phase(9'd256, 1'b0, 260, 85, 5);
      // Limit above the table size saturates; hard core with a full table.
      run_phase(9'd511, 1'b1, 60, 30, 45);
      // Single site.
      run_phase(9'd1, 1'b0, 40, 30, 40);

      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && awaited_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

### lattice_particle_occupancy_table.f
+incdir+hdl
hdl/lpot_pkg.sv
hdl/lpot_ram.sv
hdl/lattice_particle_occupancy_table.sv
hdl/lpot_checker.sv
tb/testbench.sv
